>>> rtl/crp_pkg.sv
`default_nettype none
package crp_pkg;

  localparam int unsigned SIZE_W = 9;    // ring_size register width
  localparam int unsigned ROW_W  = 128;  // one descriptor, four dwords

  // command codes
  localparam logic [2:0] CMD_ENQ    = 3'd0;
  localparam logic [2:0] CMD_CMP    = 3'd1;
  localparam logic [2:0] CMD_INIT   = 3'd2;
  localparam logic [2:0] CMD_STOP   = 3'd3;
  localparam logic [2:0] CMD_FORGET = 3'd4;

  // result status codes
  localparam logic [2:0] ST_ENQ     = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_STOPPED = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;
  localparam logic [2:0] ST_BAD     = 3'd5;
  localparam logic [2:0] ST_INIT    = 3'd6;
  localparam logic [2:0] ST_OTHER   = 3'd7;

  // register indexes
  localparam logic [7:0] REG_BASE = 8'd0;
  localparam logic [7:0] REG_SIZE = 8'd1;

  localparam logic [7:0]  CODE_SUCCESS = 8'd1;
  localparam logic [7:0]  CODE_STOPPED = 8'd24;
  localparam logic [5:0]  LINK_TYPE    = 6'd6;
  localparam logic [11:0] VAL_BIAS     = 12'hC18;  // -1000

  typedef struct packed {
    logic capture;  // latch input transaction
    logic dec;      // execute decoded command
    logic chk;      // completion pointer check
    logic cfin;     // completion finish with waiter tag
    logic lrd;      // read link slot
    logic lwr;      // update link slot cycle bit
  } crp_cmd_t;

  typedef struct packed {
    logic is_cmp;
    logic wrap;
    logic chk_read;
    logic out_free;
  } crp_sts_t;

endpackage
`default_nettype wire

>>> rtl/crp_ram.sv
`default_nettype none
module crp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/crp_ctrl.sv
`default_nettype none
module crp_ctrl import crp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire crp_sts_t sts_i,
  output crp_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_CFIN = 3'd3;
  localparam logic [2:0] S_LRD  = 3'd4;
  localparam logic [2:0] S_LWR  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_cmp) begin
          cmd_o.dec = 1'b1;
          state_d   = S_CHK;
        end else if (sts_i.out_free) begin
          cmd_o.dec = 1'b1;
          state_d   = sts_i.wrap ? S_LRD : S_IDLE;
        end
      end
      S_CHK: begin
        if (sts_i.out_free) begin
          cmd_o.chk = 1'b1;
          state_d   = sts_i.chk_read ? S_CFIN : S_IDLE;
        end
      end
      S_CFIN: begin
        if (sts_i.out_free) begin
          cmd_o.cfin = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_LRD: begin
        cmd_o.lrd = 1'b1;
        state_d   = S_LWR;
      end
      S_LWR: begin
        if (sts_i.out_free) begin
          cmd_o.lwr = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/crp_dp.sv
`default_nettype none
module crp_dp import crp_pkg::*; #(
  parameter int unsigned RING_DEPTH = 256,
  localparam int unsigned IDX_W = $clog2(RING_DEPTH)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire crp_cmd_t    cmd_i,
  output crp_sts_t         sts_o,
  input  wire logic        cfg_valid_i,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic [2:0]  cmd_in_i,
  input  wire logic [31:0] word_a_i,
  input  wire logic [31:0] word_b_i,
  input  wire logic [31:0] word_c_i,
  input  wire logic [31:0] word_d_i,
  input  wire logic [5:0]  trb_type_i,
  input  wire logic [7:0]  waiter_tag_i,
  input  wire logic [7:0]  entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic             write_valid_o,
  output logic [7:0]       write_index_o,
  output logic [31:0]      out_a_o,
  output logic [31:0]      out_b_o,
  output logic [31:0]      out_c_o,
  output logic [31:0]      out_d_o,
  output logic             waiter_valid_o,
  output logic [7:0]       waiter_out_o,
  output logic [11:0]      cmd_value_o,
  output logic             stop_flag_o,
  output logic             last_o
);

  // configuration
  logic [63:0]       base_q;
  logic [SIZE_W-1:0] size_q;

  // captured transaction
  logic [2:0]  op_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  type_q;
  logic [7:0]  tag_q, eidx_q;

  // ring state
  logic [IDX_W-1:0]      enq_q, enq_d, deq_q, deq_d;
  logic                  cyc_q, cyc_d, stop_q, stop_d;
  logic [RING_DEPTH-1:0] rvalid_q, rvalid_d, wpres_q, wpres_d;
  logic [63:0]           diff_q;
  logic                  zero_q;

  // memory ports
  logic             ring_we, ring_re, tag_we, tag_re;
  logic [IDX_W-1:0] ring_waddr, tag_raddr;
  logic [ROW_W-1:0] ring_wdata, ring_rdata;
  logic [7:0]       tag_rdata;

  // result being emitted
  logic             emit;
  logic [2:0]       e_status;
  logic             e_wv, e_wav, e_last;
  logic [IDX_W-1:0] e_widx;
  logic [ROW_W-1:0] e_row;
  logic [7:0]       e_tag;
  logic [11:0]      e_val;

  // decode
  logic [SIZE_W-1:0] n_sz;
  logic [IDX_W-1:0]  last_idx, next_pos, slot, nidx;
  logic              full, bad, stopped;
  logic [7:0]        code;
  logic [31:0]       d_new;
  logic [ROW_W-1:0]  link_row;

  always_comb begin
    if (size_q < SIZE_W'(4)) begin
      n_sz = SIZE_W'(4);
    end else if (size_q > SIZE_W'(RING_DEPTH)) begin
      n_sz = SIZE_W'(RING_DEPTH);
    end else begin
      n_sz = size_q;
    end
    last_idx = IDX_W'(n_sz - SIZE_W'(1));
    next_pos = (SIZE_W'(enq_q) < n_sz - SIZE_W'(2)) ? enq_q + IDX_W'(1) : '0;
    full     = (next_pos == deq_q);
    d_new    = {d_q[31:16], type_q, d_q[9:1], cyc_q};
    code     = c_q[31:24];
    stopped  = (code == CODE_STOPPED);
    slot     = diff_q[4 +: IDX_W];
    bad      = diff_q[63] || (diff_q[63:4] >= 60'(n_sz - SIZE_W'(1)));
    nidx     = (SIZE_W'(slot) + SIZE_W'(1) >= n_sz - SIZE_W'(1)) ? '0 : slot + IDX_W'(1);
    link_row = rvalid_q[last_idx] ? ring_rdata : '0;
    link_row[96] = cyc_q;
  end

  assign sts_o.is_cmp   = (op_q == CMD_CMP);
  assign sts_o.wrap     = (op_q == CMD_ENQ) && !full && (next_pos == '0);
  assign sts_o.chk_read = !zero_q && !bad && !stopped;
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    enq_d      = enq_q;
    deq_d      = deq_q;
    cyc_d      = cyc_q;
    stop_d     = stop_q;
    rvalid_d   = rvalid_q;
    wpres_d    = wpres_q;
    ring_we    = 1'b0;
    ring_re    = cmd_i.lrd;
    ring_waddr = enq_q;
    ring_wdata = {d_new, c_q, b_q, a_q};
    tag_we     = 1'b0;
    tag_re     = cmd_i.chk;
    tag_raddr  = slot;
    emit       = 1'b0;
    e_status   = ST_OTHER;
    e_wv       = 1'b0;
    e_widx     = '0;
    e_row      = '0;
    e_wav      = 1'b0;
    e_tag      = '0;
    e_val      = '0;
    e_last     = 1'b1;

    if (cmd_i.dec && (op_q != CMD_CMP)) begin
      emit = 1'b1;
      unique case (op_q)
        CMD_ENQ: begin
          if (full) begin
            e_status = ST_FULL;
          end else begin
            ring_we         = 1'b1;
            tag_we          = 1'b1;
            rvalid_d[enq_q] = 1'b1;
            wpres_d[enq_q]  = 1'b1;
            enq_d           = next_pos;
            e_status        = ST_ENQ;
            e_wv            = 1'b1;
            e_widx          = enq_q;
            e_row           = ring_wdata;
            e_last          = (next_pos != '0);
          end
        end
        CMD_INIT: begin
          ring_we    = 1'b1;
          ring_waddr = last_idx;
          ring_wdata = {16'd0, LINK_TYPE, 10'b10, 32'd0, base_q[63:32], base_q[31:0]};
          rvalid_d   = '0;
          rvalid_d[last_idx] = 1'b1;
          wpres_d    = '0;
          cyc_d      = 1'b1;
          enq_d      = '0;
          deq_d      = '0;
          stop_d     = 1'b0;
          e_status   = ST_INIT;
          e_wv       = 1'b1;
          e_widx     = last_idx;
          e_row      = ring_wdata;
        end
        CMD_STOP: stop_d = 1'b1;
        CMD_FORGET: begin
          if (SIZE_W'(eidx_q) < SIZE_W'(RING_DEPTH)) begin
            wpres_d[eidx_q[IDX_W-1:0]] = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.chk && !sts_o.chk_read) begin
      emit = 1'b1;
      if (zero_q) begin
        e_status = ST_ZERO;
      end else if (bad) begin
        e_status = ST_BAD;
      end else begin
        e_status = ST_STOPPED;
        deq_d    = slot;
        stop_d   = 1'b0;
      end
    end

    if (cmd_i.cfin) begin
      emit           = 1'b1;
      e_status       = ST_DONE;
      e_wav          = wpres_q[slot];
      wpres_d[slot]  = 1'b0;
      deq_d          = nidx;
      if (wpres_q[slot]) begin
        e_tag = tag_rdata;
        e_val = (code == CODE_SUCCESS) ? {4'd0, d_q[31:24]} : VAL_BIAS - {4'd0, code};
      end
    end

    if (cmd_i.lwr) begin
      emit               = 1'b1;
      ring_we            = 1'b1;
      ring_waddr         = last_idx;
      ring_wdata         = link_row;
      rvalid_d[last_idx] = 1'b1;
      cyc_d              = !cyc_q;
      e_status           = ST_ENQ;
      e_wv               = 1'b1;
      e_widx             = last_idx;
      e_row              = link_row;
    end
  end

  crp_ram #(.WIDTH(ROW_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (last_idx),
    .rdata_o (ring_rdata)
  );

  crp_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (enq_q),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= cmd_in_i;
      a_q    <= word_a_i;
      b_q    <= word_b_i;
      c_q    <= word_c_i;
      d_q    <= word_d_i;
      type_q <= trb_type_i;
      tag_q  <= waiter_tag_i;
      eidx_q <= entry_index_i;
    end
    if (cmd_i.dec) begin
      diff_q <= {b_q, a_q} - base_q;
      zero_q <= ({b_q, a_q} == 64'd0);
    end
    if (emit) begin
      status_o       <= e_status;
      write_valid_o  <= e_wv;
      write_index_o  <= 8'(e_widx);
      out_a_o        <= e_row[31:0];
      out_b_o        <= e_row[63:32];
      out_c_o        <= e_row[95:64];
      out_d_o        <= e_row[127:96];
      waiter_valid_o <= e_wav;
      waiter_out_o   <= e_tag;
      cmd_value_o    <= e_val;
      stop_flag_o    <= stop_d;
      last_o         <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      size_q      <= SIZE_W'(256);
      enq_q       <= '0;
      deq_q       <= '0;
      cyc_q       <= 1'b1;
      stop_q      <= 1'b0;
      rvalid_q    <= '0;
      wpres_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == REG_BASE)) begin
        base_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == REG_SIZE)) begin
        size_q <= cfg_data_i[SIZE_W-1:0];
      end
      enq_q    <= enq_d;
      deq_q    <= deq_d;
      cyc_q    <= cyc_d;
      stop_q   <= stop_d;
      rvalid_q <= rvalid_d;
      wpres_q  <= wpres_d;
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/command_ring_producer.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o   cmd, word_a..d, trb_type, waiter_tag, entry_index
// result    out        out_valid_o/out_stall_i status, write_*, out_a..d, waiter_*, cmd_value, ...
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i (0 base, 1 size), cfg_data_i
//
// One command at a time. Init, stop, forget and a non-wrapping enqueue run
// capture, execute; a completion runs capture, subtract, range check and,
// if that passes, waiter tag read; a wrapping enqueue adds the registered
// read-modify-write of the link slot in the ring memory.
// Reset is asynchronous; no ring clearing pass, per-slot valid bits make an
// unwritten slot read as zero. Output stall holds the result register and
// the next execute step waits on it.
module command_ring_producer import crp_pkg::*; #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [31:0]        word_a_i,
  input  wire logic [31:0]        word_b_i,
  input  wire logic [31:0]        word_c_i,
  input  wire logic [31:0]        word_d_i,
  input  wire logic [5:0]         trb_type_i,
  input  wire logic [7:0]         waiter_tag_i,
  input  wire logic [7:0]         entry_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic                    write_valid_o,
  output logic [7:0]              write_index_o,
  output logic [31:0]             out_a_o,
  output logic [31:0]             out_b_o,
  output logic [31:0]             out_c_o,
  output logic [31:0]             out_d_o,
  output logic                    waiter_valid_o,
  output logic [7:0]              waiter_out_o,
  output logic signed [11:0]      cmd_value_o,
  output logic                    stop_flag_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  crp_cmd_t    cmd;
  crp_sts_t    sts;
  logic [11:0] value;

  // the user must write registers only while idle (not enforced here), so always ready
  assign cfg_ready_o = 1'b1;
  assign cmd_value_o = signed'(value);

  crp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crp_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_in_i       (cmd_i),
    .word_a_i       (word_a_i),
    .word_b_i       (word_b_i),
    .word_c_i       (word_c_i),
    .word_d_i       (word_d_i),
    .trb_type_i     (trb_type_i),
    .waiter_tag_i   (waiter_tag_i),
    .entry_index_i  (entry_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .write_valid_o  (write_valid_o),
    .write_index_o  (write_index_o),
    .out_a_o        (out_a_o),
    .out_b_o        (out_b_o),
    .out_c_o        (out_c_o),
    .out_d_o        (out_d_o),
    .waiter_valid_o (waiter_valid_o),
    .waiter_out_o   (waiter_out_o),
    .cmd_value_o    (value),
    .stop_flag_o    (stop_flag_o),
    .last_o         (last_o)
  );

`ifndef NO_ASSERTIONS
  // a result without a ring write carries no descriptor
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_index_o == 8'd0 && out_d_o == 32'd0)
    else $error("descriptor fields set without write");

  // a waiter is only ever released by a completed command
  a_waiter_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && waiter_valid_o |-> status_o == ST_DONE)
    else $error("waiter released outside completion");

  // a wrapping enqueue is the only two-result transaction; a result with last_o low is an enqueue with a ring write
  a_first_is_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_ENQ && write_valid_o)
    else $error("non-final result outside wrap");

  // no waiter, no value
  a_no_waiter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !waiter_valid_o |-> waiter_out_o == 8'd0 && value == 12'd0)
    else $error("waiter fields set without waiter");
`endif

endmodule
`default_nettype wire
